@@ src/lfsrdb_pkg.sv @@
// Package with the shared types and constants of the LFSR de Bruijn string generator.
package lfsrdb_pkg;

    localparam int OrderWidth    = 5;
    localparam int TapMaskWidth  = 17;
    localparam int CfgIndexWidth = 1;
    localparam int CfgDataWidth  = 17;

    localparam logic [CfgIndexWidth-1:0] RegOrder   = 1'b0;
    localparam logic [CfgIndexWidth-1:0] RegTapMask = 1'b1;

    localparam logic [OrderWidth-1:0]   OrderReset   = 5'd5;
    localparam logic [TapMaskWidth-1:0] TapMaskReset = 17'd37;

    typedef struct packed {
        logic [OrderWidth-1:0]   order;
        logic [TapMaskWidth-1:0] tap_mask;
    } cfg_t;

    typedef struct packed {
        logic seq_bit;
        logic final_bit;
        logic idle;
    } result_t;

endpackage

@@ src/lfsr_de_bruijn_generator.sv @@
// Top level of the LFSR de Bruijn string generator with its stream ports.
// Each accepted input transaction produces exactly one output transaction carrying the next
// bit of a linear de Bruijn string of order n (2^n + n - 1 bits, the first one emitted as 0
// and the last one marked by tlast); ticks after the end report idle in tuser until a
// transaction with restart set begins a new string. One transaction is accepted every clock
// cycle while the output side keeps taking results; each one passes through the input
// register and then the result register, with the tap parity computed between them.
// The order and tap mask are written through the configuration port; the user must write them while no
// transaction is in flight, as the block does not enforce it, and they take effect on the next tick.
module lfsr_de_bruijn_generator #(
    parameter int MAX_ORDER = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [0] restart
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,   // [0] seq_bit
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tuser,   // [0] idle
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lfsrdb_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lfsrdb_pkg::CfgDataWidth-1:0]  cfg_data
);
    import lfsrdb_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic in_valid_reg;
    logic in_restart_reg;
    logic out_valid_reg;
    logic out_seq_bit_reg;
    logic out_final_reg;
    logic out_idle_reg;
    logic advance;
    logic take_in;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    lfsrdb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfsrdb_core #(
        .MAX_ORDER (MAX_ORDER)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_restart_reg <= s_axis_tdata[0];
        if (advance)
        begin
            out_seq_bit_reg <= result.seq_bit;
            out_final_reg   <= result.final_bit;
            out_idle_reg    <= result.idle;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_seq_bit_reg};
    assign m_axis_tlast  = out_final_reg;
    assign m_axis_tuser  = out_idle_reg;

endmodule

@@ src/lfsrdb_cfg.sv @@
// Configuration registers of the LFSR de Bruijn string generator.
module lfsrdb_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfsrdb_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lfsrdb_pkg::CfgDataWidth-1:0]  cfg_data,
    output lfsrdb_pkg::cfg_t                    cfg
);
    import lfsrdb_pkg::*;

    logic [OrderWidth-1:0]   order_reg;
    logic [TapMaskWidth-1:0] tap_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg    <= OrderReset;
            tap_mask_reg <= TapMaskReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                RegOrder:   order_reg    <= cfg_data[OrderWidth-1:0];
                RegTapMask: tap_mask_reg <= cfg_data[TapMaskWidth-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg.order    = order_reg;
    assign cfg.tap_mask = tap_mask_reg;

endmodule

@@ src/lfsrdb_core.sv @@
// String state and next-bit logic of the LFSR de Bruijn string generator.
module lfsrdb_core #(
    parameter int MAX_ORDER = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 restart,
    input  lfsrdb_pkg::cfg_t     cfg,
    output lfsrdb_pkg::result_t  result
);
    import lfsrdb_pkg::*;

    localparam int OrdW = $clog2(MAX_ORDER + 1);
    localparam int PosW = MAX_ORDER + 1;
    localparam int TapBits = TapMaskWidth - 1;

    logic [MAX_ORDER-1:0] history_reg;
    logic [MAX_ORDER-1:0] history_next;
    logic [PosW-1:0]      position_reg;
    logic [PosW-1:0]      position_next;
    logic                 active_reg;
    logic                 active_next;

    logic [OrdW-1:0]      n_eff;
    logic [MAX_ORDER-1:0] taps;
    logic [MAX_ORDER-1:0] order_mask;
    logic [MAX_ORDER-1:0] hist_eff;
    logic [PosW-1:0]      pos_eff;
    logic                 act_eff;
    logic [PosW-1:0]      last_pos;
    logic                 reg_bit;
    logic                 fin;

    always_comb
    begin
        if (cfg.order == '0)
            n_eff = OrdW'(1);
        else if (32'(cfg.order) > MAX_ORDER)
            n_eff = OrdW'(MAX_ORDER);
        else
            n_eff = OrdW'(cfg.order);
    end

    for (genvar i = 0; i < MAX_ORDER; i++)
    begin : g_taps
        if (i < TapBits)
        begin : g_used
            assign taps[i] = cfg.tap_mask[i+1];
        end
        else
        begin : g_unused
            assign taps[i] = 1'b0;
        end
        assign order_mask[i] = (OrdW'(i) < n_eff);
    end

    assign hist_eff = restart ? '0 : history_reg;
    assign pos_eff  = restart ? '0 : position_reg;
    assign act_eff  = restart | active_reg;

    assign last_pos = (PosW'(1) << n_eff) + PosW'(n_eff) - PosW'(2);

    always_comb
    begin
        if (pos_eff < PosW'(n_eff))
            reg_bit = (pos_eff == '0);
        else
            reg_bit = ^(hist_eff & taps & order_mask);
    end

    assign fin = (pos_eff >= last_pos);

    always_comb
    begin
        history_next  = history_reg;
        position_next = position_reg;
        active_next   = active_reg;
        if (act_eff)
        begin
            history_next  = {hist_eff[MAX_ORDER-2:0], reg_bit};
            position_next = pos_eff + PosW'(1);
            active_next   = !fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg  <= '0;
            position_reg <= '0;
            active_reg   <= 1'b0;
        end
        else if (step)
        begin
            history_reg  <= history_next;
            position_reg <= position_next;
            active_reg   <= active_next;
        end
    end

    assign result.seq_bit   = act_eff && (pos_eff != '0) && reg_bit;
    assign result.final_bit = act_eff && fin;
    assign result.idle      = !act_eff;

endmodule
